### design/prb_pkg.sv
// Shared widths, codes, types and rounding helpers for the projective bounding box.
package prb_pkg;

  localparam int CoordW     = 17;
  localparam int CoefW      = 32;
  localparam int ProdW      = CoefW + CoordW;
  localparam int DenW       = 51;
  localparam int DenMagW    = DenW - 1;
  localparam int NumW       = 58;
  localparam int NumMagW    = NumW - 1;
  localparam int DivSteps   = 25;
  localparam int QuoW       = DivSteps;
  localparam int BoxW       = 24;
  localparam int CfgW       = 64;
  localparam int CfgIdxW    = 3;
  localparam int NumCorners = 4;
  localparam int CornerLat  = 4;
  localparam int ReduceLat  = 2;
  localparam int PipeLat    = CornerLat + DivSteps + ReduceLat;

  localparam logic signed [BoxW-1:0] BoxMax = {1'b0, {(BoxW-1){1'b1}}};
  localparam logic signed [BoxW-1:0] BoxMin = {1'b1, {(BoxW-1){1'b0}}};
  localparam logic signed [DenW-1:0] WOne   = DenW'(1) << 31;
  localparam logic signed [DenW-1:0] WTiny  = DenW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_M0_M1 = 3'd0,
    CFG_M2_M3 = 3'd1,
    CFG_M4_M5 = 3'd2,
    CFG_M6_M7 = 3'd3,
    CFG_M8    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0] m0;
    logic [CoefW-1:0] m1;
    logic [CoefW-1:0] m2;
    logic [CoefW-1:0] m3;
    logic [CoefW-1:0] m4;
    logic [CoefW-1:0] m5;
    logic [CoefW-1:0] m6;
    logic [CoefW-1:0] m7;
    logic [CoefW-1:0] m8;
  } coef_t;

  // One division request: magnitudes plus the sign of the true quotient.
  typedef struct packed {
    logic [NumMagW-1:0] num;
    logic [DenMagW-1:0] den;
    logic               neg;
  } div_req_t;

  // The top quotient bit flags a magnitude of 2^24 or more.
  typedef struct packed {
    logic [QuoW-1:0] quo;
    logic            rem_nz;
    logic            neg;
  } div_res_t;

  // Floor (up = 0) or ceiling (up = 1) of the signed quotient, clamped to 24 bits.
  function automatic logic signed [BoxW-1:0] round_box(div_res_t r, logic up);
    logic signed [BoxW+1:0] v;
    logic signed [BoxW+1:0] adj;
    logic signed [BoxW-1:0] res;
    adj = (BoxW+2)'(r.rem_nz);
    v   = $signed({2'b00, r.quo[QuoW-2:0]});
    if (r.neg) begin
      v = -v;
      if (!up) v = v - adj;
    end else if (up) begin
      v = v + adj;
    end
    if (r.quo[QuoW-1]) begin
      res = r.neg ? BoxMin : BoxMax;
    end else if (v > (BoxW+2)'(BoxMax)) begin
      res = BoxMax;
    end else if (v < (BoxW+2)'(BoxMin)) begin
      res = BoxMin;
    end else begin
      res = v[BoxW-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [BoxW-1:0] min2(logic signed [BoxW-1:0] a,
                                                   logic signed [BoxW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [BoxW-1:0] max2(logic signed [BoxW-1:0] a,
                                                   logic signed [BoxW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

### design/prb_corner.sv
// Four-stage corner mapper: products, homogeneous sums, then sign and magnitude split.
module prb_corner (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  prb_pkg::coef_t                        coef_i,
  input  logic signed [prb_pkg::CoordW-1:0]     x_i,
  input  logic signed [prb_pkg::CoordW-1:0]     y_i,
  output prb_pkg::div_req_t                     req_x_o,
  output prb_pkg::div_req_t                     req_y_o
);

  logic signed [prb_pkg::CoordW-1:0] x_q, y_q;
  logic signed [prb_pkg::CoefW-1:0]  m0, m1, m2, m3, m4, m5, m6, m7, m8;
  logic signed [prb_pkg::ProdW-1:0]  p0_d, p1_d, p3_d, p4_d, p6_d, p7_d;
  logic signed [prb_pkg::ProdW-1:0]  p0_q, p1_q, p3_q, p4_q, p6_q, p7_q;
  logic signed [prb_pkg::DenW-1:0]   w_d, w_q, w_fix;
  logic signed [prb_pkg::NumW-1:0]   nx_d, ny_d, nx_q, ny_q;
  prb_pkg::div_req_t                 req_x_d, req_y_d, req_x_q, req_y_q;
  logic [prb_pkg::DenMagW-1:0]       den_mag;

  assign m0 = $signed(coef_i.m0);
  assign m1 = $signed(coef_i.m1);
  assign m2 = $signed(coef_i.m2);
  assign m3 = $signed(coef_i.m3);
  assign m4 = $signed(coef_i.m4);
  assign m5 = $signed(coef_i.m5);
  assign m6 = $signed(coef_i.m6);
  assign m7 = $signed(coef_i.m7);
  assign m8 = $signed(coef_i.m8);

  assign p0_d = m0 * x_q;
  assign p1_d = m1 * y_q;
  assign p3_d = m3 * x_q;
  assign p4_d = m4 * y_q;
  assign p6_d = m6 * x_q;
  assign p7_d = m7 * y_q;

  // w is in Q.31, the numerators in Q.24 scaled by 2^7 so that num / w is the coordinate.
  assign w_d  = prb_pkg::DenW'(p6_q) + prb_pkg::DenW'(p7_q) + (prb_pkg::DenW'(m8) <<< 7);
  assign nx_d = (prb_pkg::NumW'(p0_q) + prb_pkg::NumW'(p1_q) + (prb_pkg::NumW'(m2) <<< 8)) <<< 7;
  assign ny_d = (prb_pkg::NumW'(p3_q) + prb_pkg::NumW'(p4_q) + (prb_pkg::NumW'(m5) <<< 8)) <<< 7;

  // A w of magnitude two or less counts as 1.0.
  assign w_fix   = (w_q >= -prb_pkg::WTiny && w_q <= prb_pkg::WTiny) ? prb_pkg::WOne : w_q;
  assign den_mag = w_fix[prb_pkg::DenW-1] ? prb_pkg::DenMagW'(-w_fix)
                                          : prb_pkg::DenMagW'(w_fix);

  always_comb begin
    req_x_d.den = den_mag;
    req_y_d.den = den_mag;
    req_x_d.num = nx_q[prb_pkg::NumW-1] ? prb_pkg::NumMagW'(-nx_q) : prb_pkg::NumMagW'(nx_q);
    req_y_d.num = ny_q[prb_pkg::NumW-1] ? prb_pkg::NumMagW'(-ny_q) : prb_pkg::NumMagW'(ny_q);
    req_x_d.neg = nx_q[prb_pkg::NumW-1] ^ w_fix[prb_pkg::DenW-1];
    req_y_d.neg = ny_q[prb_pkg::NumW-1] ^ w_fix[prb_pkg::DenW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_i;
      y_q     <= y_i;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      p3_q    <= p3_d;
      p4_q    <= p4_d;
      p6_q    <= p6_d;
      p7_q    <= p7_d;
      w_q     <= w_d;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      req_x_q <= req_x_d;
      req_y_q <= req_y_d;
    end
  end

  assign req_x_o = req_x_q;
  assign req_y_o = req_y_q;

endmodule

### design/prb_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient magnitude below 2^25.
module prb_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  prb_pkg::div_req_t  req_i,
  output prb_pkg::div_res_t  res_o
);

  localparam int Last = prb_pkg::DivSteps - 1;

  logic [prb_pkg::NumMagW-1:0] rem_q [prb_pkg::DivSteps];
  logic [prb_pkg::QuoW-1:0]    quo_q [prb_pkg::DivSteps];
  logic [prb_pkg::DenMagW-1:0] den_q [prb_pkg::DivSteps];
  logic                        neg_q [prb_pkg::DivSteps];

  for (genvar k = 0; k < prb_pkg::DivSteps; k++) begin : g_step
    localparam int Bit = prb_pkg::DivSteps - 1 - k;
    logic [prb_pkg::NumMagW-1:0] rem_in, sub;
    logic [prb_pkg::QuoW-1:0]    quo_in;
    logic [prb_pkg::DenMagW-1:0] den_in;
    logic                        neg_in, ge;

    if (k == 0) begin : g_first
      assign rem_in = req_i.num;
      assign quo_in = '0;
      assign den_in = req_i.den;
      assign neg_in = req_i.neg;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    // Shifting the remainder down avoids a compare wider than the remainder.
    assign ge  = (rem_in >> Bit) >= prb_pkg::NumMagW'(den_in);
    assign sub = rem_in - (prb_pkg::NumMagW'(den_in) << Bit);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? sub : rem_in;
        quo_q[k] <= quo_in | (ge ? (prb_pkg::QuoW'(1) << Bit) : '0);
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  assign res_o.quo    = quo_q[Last];
  assign res_o.rem_nz = |rem_q[Last];
  assign res_o.neg    = neg_q[Last];

endmodule

### design/prb_reduce.sv
// Floor and ceiling per corner, min and max over corners, and the output register.
module prb_reduce (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic                               emp_i,
  input  prb_pkg::div_res_t                  res_x_i [prb_pkg::NumCorners],
  input  prb_pkg::div_res_t                  res_y_i [prb_pkg::NumCorners],
  output logic                               out_valid_o,
  output logic signed [prb_pkg::BoxW-1:0]    box_left_o,
  output logic signed [prb_pkg::BoxW-1:0]    box_top_o,
  output logic [prb_pkg::BoxW-1:0]           box_span_x_o,
  output logic [prb_pkg::BoxW-1:0]           box_span_y_o,
  output logic                               box_empty_o
);

  logic signed [prb_pkg::BoxW-1:0] fx_q [prb_pkg::NumCorners];
  logic signed [prb_pkg::BoxW-1:0] fy_q [prb_pkg::NumCorners];
  logic signed [prb_pkg::BoxW-1:0] cx_q [prb_pkg::NumCorners];
  logic signed [prb_pkg::BoxW-1:0] cy_q [prb_pkg::NumCorners];
  logic signed [prb_pkg::BoxW-1:0] minx_q, miny_q, maxx_q, maxy_q;
  logic signed [prb_pkg::BoxW-1:0] left_q, top_q;
  logic [prb_pkg::BoxW-1:0]        spx_q, spy_q;
  logic                            empty_q, valid_q, blank;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < prb_pkg::NumCorners; c++) begin
        fx_q[c] <= prb_pkg::round_box(res_x_i[c], 1'b0);
        fy_q[c] <= prb_pkg::round_box(res_y_i[c], 1'b0);
        cx_q[c] <= prb_pkg::round_box(res_x_i[c], 1'b1);
        cy_q[c] <= prb_pkg::round_box(res_y_i[c], 1'b1);
      end
      minx_q <= prb_pkg::min2(prb_pkg::min2(fx_q[0], fx_q[1]), prb_pkg::min2(fx_q[2], fx_q[3]));
      miny_q <= prb_pkg::min2(prb_pkg::min2(fy_q[0], fy_q[1]), prb_pkg::min2(fy_q[2], fy_q[3]));
      maxx_q <= prb_pkg::max2(prb_pkg::max2(cx_q[0], cx_q[1]), prb_pkg::max2(cx_q[2], cx_q[3]));
      maxy_q <= prb_pkg::max2(prb_pkg::max2(cy_q[0], cy_q[1]), prb_pkg::max2(cy_q[2], cy_q[3]));
    end
  end

  // Empty input or a box that collapsed on either axis, saturation included.
  assign blank = emp_i || (maxx_q <= minx_q) || (maxy_q <= miny_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_q  <= blank ? '0 : minx_q;
      top_q   <= blank ? '0 : miny_q;
      spx_q   <= blank ? '0 : prb_pkg::BoxW'(maxx_q - minx_q);
      spy_q   <= blank ? '0 : prb_pkg::BoxW'(maxy_q - miny_q);
      empty_q <= blank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vld_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign box_left_o   = left_q;
  assign box_top_o    = top_q;
  assign box_span_x_o = spx_q;
  assign box_span_y_o = spy_q;
  assign box_empty_o  = empty_q;

endmodule

### design/projective_rect_bounding_box.sv
// Top level: coefficient registers, corner mappers, dividers and the result stage.
// Maps a rectangle through a 3x3 fixed-point projective matrix and returns the integer
// bounding box of its four corners. One request enters per clock cycle while the pipeline
// is not stalled. A request passes through a four-stage corner mapper, the 25-stage
// restoring dividers, one per corner coordinate, and a three-stage min/max and output
// section. While a result waits with out_stall_i high, the whole pipeline holds and
// in_stall_o is raised. Coefficients reset to the identity; the user must write them
// through cfg_we_i only while no request is in flight, which the block does not enforce.
module projective_rect_bounding_box (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prb_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [prb_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [15:0]                  rect_left_i,
  input  logic signed [15:0]                  rect_top_i,
  input  logic signed [15:0]                  rect_span_x_i,
  input  logic signed [15:0]                  rect_span_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [prb_pkg::BoxW-1:0]     box_left_o,
  output logic signed [prb_pkg::BoxW-1:0]     box_top_o,
  output logic [prb_pkg::BoxW-1:0]            box_span_x_o,
  output logic [prb_pkg::BoxW-1:0]            box_span_y_o,
  output logic                                box_empty_o
);

  localparam logic [prb_pkg::CfgW-1:0]  OneQ24   = prb_pkg::CfgW'(1) << 24;
  localparam logic [prb_pkg::CoefW-1:0] OneQ24_32 = prb_pkg::CoefW'(1) << 24;

  logic [prb_pkg::CfgW-1:0]  m01_q, m23_q, m45_q, m67_q;
  logic [prb_pkg::CoefW-1:0] m8_q;
  prb_pkg::coef_t            coef;
  logic                      en, in_empty;
  logic                      vld_q [prb_pkg::PipeLat];
  logic                      emp_q [prb_pkg::PipeLat];
  logic signed [prb_pkg::CoordW-1:0] x0, x1, y0, y1;
  prb_pkg::div_req_t         req_x [prb_pkg::NumCorners];
  prb_pkg::div_req_t         req_y [prb_pkg::NumCorners];
  prb_pkg::div_res_t         res_x [prb_pkg::NumCorners];
  prb_pkg::div_res_t         res_y [prb_pkg::NumCorners];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m01_q <= OneQ24;
      m23_q <= '0;
      m45_q <= OneQ24;
      m67_q <= '0;
      m8_q  <= OneQ24_32;
    end else if (cfg_we_i) begin
      case (prb_pkg::cfg_idx_e'(cfg_idx_i))
        prb_pkg::CFG_M0_M1: m01_q <= cfg_data_i;
        prb_pkg::CFG_M2_M3: m23_q <= cfg_data_i;
        prb_pkg::CFG_M4_M5: m45_q <= cfg_data_i;
        prb_pkg::CFG_M6_M7: m67_q <= cfg_data_i;
        prb_pkg::CFG_M8:    m8_q  <= cfg_data_i[prb_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.m0 = m01_q[31:0];
    coef.m1 = m01_q[63:32];
    coef.m2 = m23_q[31:0];
    coef.m3 = m23_q[63:32];
    coef.m4 = m45_q[31:0];
    coef.m5 = m45_q[63:32];
    coef.m6 = m67_q[31:0];
    coef.m7 = m67_q[63:32];
    coef.m8 = m8_q;
  end

  // The pipeline advances unless a finished result is held back.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign in_empty = rect_span_x_i[15] || (rect_span_x_i == '0) ||
                    rect_span_y_i[15] || (rect_span_y_i == '0);

  assign x0 = prb_pkg::CoordW'(rect_left_i);
  assign y0 = prb_pkg::CoordW'(rect_top_i);
  assign x1 = prb_pkg::CoordW'(rect_left_i) + prb_pkg::CoordW'(rect_span_x_i);
  assign y1 = prb_pkg::CoordW'(rect_top_i) + prb_pkg::CoordW'(rect_span_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < prb_pkg::PipeLat; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < prb_pkg::PipeLat; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      emp_q[0] <= in_empty;
      for (int k = 1; k < prb_pkg::PipeLat; k++) emp_q[k] <= emp_q[k-1];
    end
  end

  for (genvar c = 0; c < prb_pkg::NumCorners; c++) begin : g_corner
    prb_corner u_corner (
      .clk_i   (clk_i),
      .en_i    (en),
      .coef_i  (coef),
      .x_i     ((c % 2 == 1) ? x1 : x0),
      .y_i     ((c / 2 == 1) ? y1 : y0),
      .req_x_o (req_x[c]),
      .req_y_o (req_y[c])
    );

    prb_div u_div_x (
      .clk_i (clk_i),
      .en_i  (en),
      .req_i (req_x[c]),
      .res_o (res_x[c])
    );

    prb_div u_div_y (
      .clk_i (clk_i),
      .en_i  (en),
      .req_i (req_y[c]),
      .res_o (res_y[c])
    );
  end

  prb_reduce u_reduce (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (vld_q[prb_pkg::PipeLat-1]),
    .emp_i        (emp_q[prb_pkg::PipeLat-1]),
    .res_x_i      (res_x),
    .res_y_i      (res_y),
    .out_valid_o  (out_valid_o),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_span_x_o (box_span_x_o),
    .box_span_y_o (box_span_y_o),
    .box_empty_o  (box_empty_o)
  );

endmodule

### design/prb_checker.sv
// Port-level checks for the projective bounding box, bound to the top level.
module prb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [prb_pkg::BoxW-1:0]  box_left_o,
  input logic signed [prb_pkg::BoxW-1:0]  box_top_o,
  input logic [prb_pkg::BoxW-1:0]         box_span_x_o,
  input logic [prb_pkg::BoxW-1:0]         box_span_y_o,
  input logic                             box_empty_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(box_left_o) &&
      $stable(box_top_o) && $stable(box_span_x_o) && $stable(box_span_y_o) &&
      $stable(box_empty_o))
    else $error("held result changed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && box_empty_o |-> box_left_o == '0 && box_top_o == '0 &&
      box_span_x_o == '0 && box_span_y_o == '0)
    else $error("empty result carries nonzero fields");

  a_span_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !box_empty_o |-> box_span_x_o != '0 && box_span_y_o != '0)
    else $error("non-empty result with zero span");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

bind projective_rect_bounding_box prb_checker u_prb_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for the projective rectangle bounding box.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] span_x;
    logic signed [15:0] span_y;
  } rect_t;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic [23:0]        span_x;
    logic [23:0]        span_y;
    logic               empty;
  } box_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [prb_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [prb_pkg::CfgW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic signed [15:0] rect_left_i, rect_top_i, rect_span_x_i, rect_span_y_i;
  logic out_valid_o, out_stall_i;
  logic signed [23:0] box_left_o, box_top_o;
  logic [23:0] box_span_x_o, box_span_y_o;
  logic box_empty_o;

  projective_rect_bounding_box u_dut (.*);

  // Testbench copy of the coefficient registers.
  logic [63:0] mat_r0 = 64'd16777216, mat_r1 = 64'd0, mat_r2 = 64'd16777216;
  logic [63:0] mat_r3 = 64'd0, mat_r4 = 64'd16777216;

  rect_t rect_queue[$];
  box_t  box_queue[$];
  int    n_mismatch = 0;
  int    n_boxes = 0;
  int    n_queued = 0;
  bit    calm = 0;

  function automatic longint floor_div(longint a, longint b);
    longint q, r;
    q = a / b;
    r = a % b;
    if (r != 0 && ((r < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic longint ceil_div(longint a, longint b);
    longint q, r;
    q = a / b;
    r = a % b;
    if (r != 0 && ((r < 0) == (b < 0))) q++;
    return q;
  endfunction

  function automatic longint clamp_box(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic box_t map_rect(rect_t r);
    box_t b;
    longint m0, m1, m2, m3, m4, m5, m6, m7, m8;
    longint x, y, w, nx, ny, fx, fy, cx, cy, a, bb, c, d;
    b = '0;
    b.empty = 1'b1;
    if (r.span_x <= 0 || r.span_y <= 0) return b;
    m0 = $signed(mat_r0[31:0]);  m1 = $signed(mat_r0[63:32]);
    m2 = $signed(mat_r1[31:0]);  m3 = $signed(mat_r1[63:32]);
    m4 = $signed(mat_r2[31:0]);  m5 = $signed(mat_r2[63:32]);
    m6 = $signed(mat_r3[31:0]);  m7 = $signed(mat_r3[63:32]);
    m8 = $signed(mat_r4[31:0]);
    fx = 0; fy = 0; cx = 0; cy = 0;
    for (int k = 0; k < 4; k++) begin
      x = longint'(r.left) + ((k & 1) ? longint'(r.span_x) : 0);
      y = longint'(r.top) + ((k & 2) ? longint'(r.span_y) : 0);
      w = m6 * x + m7 * y + m8 * 128;
      nx = (m0 * x + m1 * y + m2 * 256) * 128;
      ny = (m3 * x + m4 * y + m5 * 256) * 128;
      // A w this close to zero is treated as exactly one.
      if (w >= -2 && w <= 2) w = 64'sd2147483648;
      a = floor_div(nx, w); bb = floor_div(ny, w);
      c = ceil_div(nx, w);  d = ceil_div(ny, w);
      if (k == 0 || a < fx) fx = a;
      if (k == 0 || bb < fy) fy = bb;
      if (k == 0 || c > cx) cx = c;
      if (k == 0 || d > cy) cy = d;
    end
    fx = clamp_box(fx); fy = clamp_box(fy);
    cx = clamp_box(cx); cy = clamp_box(cy);
    if (cx <= fx || cy <= fy) return b;
    b.left = fx[23:0]; b.top = fy[23:0];
    b.span_x = 24'(cx - fx); b.span_y = 24'(cy - fy);
    b.empty = 1'b0;
    return b;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: presents queued requests, idles at random except in calm stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      rect_left_i <= 0; rect_top_i <= 0; rect_span_x_i <= 0; rect_span_y_i <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        box_queue = {box_queue, map_rect({rect_left_i, rect_top_i, rect_span_x_i,
                                          rect_span_y_i})};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rect_queue.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
          rect_t r;
          r = rect_queue.pop_front();
          in_valid_i <= 1;
          rect_left_i <= r.left; rect_top_i <= r.top;
          rect_span_x_i <= r.span_x; rect_span_y_i <= r.span_y;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks each result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        box_t got, want;
        got = {box_left_o, box_top_o, box_span_x_o, box_span_y_o, box_empty_o};
        n_boxes++;
        if (box_queue.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("Unexpected result %h", got);
        end else begin
          want = box_queue.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display({"Box mismatch: expected l=%0d t=%0d sx=%0d sy=%0d e=%0b,",
                        " got l=%0d t=%0d sx=%0d sy=%0d e=%0b"},
                       want.left, want.top, want.span_x, want.span_y, want.empty,
                       got.left, got.top, got.span_x, got.span_y, got.empty);
          end
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 13);
    end
  end

  task automatic queue_rect(int l, int t, int sx, int sy);
    rect_t r;
    r = {16'(l), 16'(t), 16'(sx), 16'(sy)};
    rect_queue = {rect_queue, r};
    n_queued++;
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $signed(16'($urandom));
      1: return $urandom_range(200) - 100;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
    endcase
  endfunction

  function automatic int rand_span();
    case ($urandom_range(5))
      0: return $signed(16'($urandom));
      1: return -$urandom_range(3);
      2: return 32767 - $urandom_range(2);
      default: return $urandom_range(300) + 1;
    endcase
  endfunction

  // Holds the sender back until every queued request has produced its result.
  task automatic wait_drained();
    while (n_boxes < n_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(prb_pkg::cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      prb_pkg::CFG_M0_M1: mat_r0 = val;
      prb_pkg::CFG_M2_M3: mat_r1 = val;
      prb_pkg::CFG_M4_M5: mat_r2 = val;
      prb_pkg::CFG_M6_M7: mat_r3 = val;
      prb_pkg::CFG_M8:    mat_r4 = {32'd0, val[31:0]};
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coef(logic [31:0] unit);
    case ($urandom_range(4))
      0: return $urandom;
      1: return unit;
      2: return 32'($signed(unit) >>> $urandom_range(4)) * ($urandom_range(1) ? 1 : -1);
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(65535)) - 32'd32768;
    endcase
  endfunction

  function automatic logic [31:0] rand_persp();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'($urandom_range(4000)) - 32'd2000;
      default: return 32'($urandom_range(4)) - 32'd2;
    endcase
  endfunction

  initial begin
    cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;

    // Identity matrix: field extremes and empty inputs.
    queue_rect(0, 0, 1, 1);
    queue_rect(-32768, -32768, 32767, 32767);
    queue_rect(32767, 32767, 32767, 32767);
    queue_rect(5, 5, 0, 10);
    queue_rect(5, 5, 10, 0);
    queue_rect(5, 5, -32768, 4);
    queue_rect(5, 5, 4, -1);
    queue_rect(-1, -1, 2, 2);
    queue_rect(100, -200, 3, 7);
    wait_drained();

    // Scale of just under 128 on both axes, which keeps the boxes below saturation.
    write_reg(prb_pkg::CFG_M0_M1, {32'd0, 32'h7fffffff});
    write_reg(prb_pkg::CFG_M4_M5, {32'd0, 32'h7fffffff});
    queue_rect(30000, 30000, 100, 100);
    queue_rect(-30000, -30000, 100, 100);
    queue_rect(-10, -10, 20, 20);
    wait_drained();

    // Zero w: everything is divided by one instead.
    write_reg(prb_pkg::CFG_M8, 64'd0);
    write_reg(prb_pkg::CFG_M6_M7, 64'd0);
    queue_rect(1, 2, 3, 4);
    wait_drained();
    write_reg(prb_pkg::CFG_M8, 64'hffff_ffff_0000_0001);  // w of 128 raw, not near zero
    queue_rect(1, 2, 3, 4);
    wait_drained();
    write_reg(prb_pkg::CFG_M0_M1, 64'h8000_0000_8000_0000);
    write_reg(prb_pkg::CFG_M2_M3, 64'h7fff_ffff_8000_0000);
    write_reg(prb_pkg::CFG_M4_M5, 64'h8000_0000_7fff_ffff);
    write_reg(prb_pkg::CFG_M6_M7, 64'h7fff_ffff_8000_0000);
    write_reg(prb_pkg::CFG_M8, 64'h8000_0000);
    queue_rect(-32768, 32767, 32767, 1);
    queue_rect(7, -7, 9, 9);
    wait_drained();

    for (int phase = 0; phase < 12; phase++) begin
      write_reg(prb_pkg::CFG_M0_M1, {rand_coef(32'h0), rand_coef(32'h0100_0000)});
      write_reg(prb_pkg::CFG_M2_M3, {rand_coef(32'h0), rand_coef(32'h0001_0000)});
      write_reg(prb_pkg::CFG_M4_M5, {rand_coef(32'h0001_0000), rand_coef(32'h0100_0000)});
      write_reg(prb_pkg::CFG_M6_M7, {rand_persp(), rand_persp()});
      write_reg(prb_pkg::CFG_M8, {32'($urandom), rand_coef(32'h0100_0000)});
      if (phase == 5) write_reg(prb_pkg::cfg_idx_e'(3'd6), 64'hdead_beef);
      calm = (phase == 3);
      for (int i = 0; i < 120; i++) queue_rect(rand_coord(), rand_coord(), rand_span(), rand_span());
      wait_drained();
    end
    calm = 0;

    $display("Covered %0d boxes over directed cases and 12 random matrices.", n_boxes);
    if (n_mismatch == 0 && box_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
